// File: design/lwc_pkg.sv
// ----------------------------------------------------------------------------
// lwc_pkg
// Shared types, constants and helper functions for the line window clipper.
// ----------------------------------------------------------------------------
package lwc_pkg;

  localparam int CW          = 16;            // coordinate width
  localparam int DW          = CW + 1;        // width of coordinate differences
  localparam int PW          = 2 * DW;        // width of the |a|*|b| product
  localparam int CLIP_PASSES = 8;
  localparam int PASS_W      = $clog2(CLIP_PASSES + 1);
  localparam int BIT_W       = $clog2(PW + 1);

  localparam logic [3:0] OC_LEFT   = 4'b0001;
  localparam logic [3:0] OC_RIGHT  = 4'b0010;
  localparam logic [3:0] OC_BOTTOM = 4'b0100;
  localparam logic [3:0] OC_TOP    = 4'b1000;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_BOTTOM = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  typedef struct packed {
    logic signed [CW-1:0] left;
    logic signed [CW-1:0] bottom;
    logic signed [CW-1:0] right;
    logic signed [CW-1:0] top;
  } win_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [3:0]           oc0;
    logic [3:0]           oc1;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL,
    ST_DIV,
    ST_UPDATE
  } back_state_t;

  function automatic logic [3:0] outcode(input logic signed [CW-1:0] x,
                                         input logic signed [CW-1:0] y,
                                         input win_t w);
    logic [3:0] c;
    c = 4'b0000;
    if (y > w.top)    c = c | OC_TOP;
    if (y < w.bottom) c = c | OC_BOTTOM;
    if (x > w.right)  c = c | OC_RIGHT;
    if (x < w.left)   c = c | OC_LEFT;
    return c;
  endfunction

  function automatic logic [DW-1:0] magnitude(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic logic signed [CW-1:0] clamp(input logic signed [PW+2:0] v);
    logic signed [PW+2:0] hi;
    logic signed [PW+2:0] lo;
    hi = (PW+3)'((1 << (CW - 1)) - 1);
    lo = -hi - (PW+3)'(1);
    if (v > hi) return CW'(hi);
    if (v < lo) return CW'(lo);
    return v[CW-1:0];
  endfunction

endpackage

// File: design/line_window_clipper.sv
// ----------------------------------------------------------------------------
// line_window_clipper
// Clips line segments against a rectangular window held in four registers.
// ----------------------------------------------------------------------------
// A segment beat is taken into a two-entry queue whenever the queue has
// room. The clipping sequencer then handles one segment at a time: an idle
// and a decision state, then, for every end point it moves onto a window
// edge, a multiply state, the bit-serial divider, an update state and one
// more decision, with 0 to 8 moves per segment. The result waits in an
// output register, so the next segment starts while it is unread.
// Write the window registers only while no segment is in flight.
module line_window_clipper (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [lwc_pkg::CW-1:0]   cfg_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [4*lwc_pkg::CW-1:0] s_tdata,  // start_x, start_y, end_x, end_y
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
  output logic [4*lwc_pkg::CW-1:0] m_tdata,
  output logic                     m_tuser   // visible
);

  lwc_pkg::win_t win;
  lwc_pkg::job_t front_job;
  lwc_pkg::job_t q_job;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.left   <= '0;
      win.bottom <= '0;
      win.right  <= lwc_pkg::CW'(639);
      win.top    <= lwc_pkg::CW'(479);
    end else if (cfg_we) begin
      case (cfg_index)
        lwc_pkg::REG_LEFT:   win.left   <= cfg_data;
        lwc_pkg::REG_BOTTOM: win.bottom <= cfg_data;
        lwc_pkg::REG_RIGHT:  win.right  <= cfg_data;
        lwc_pkg::REG_TOP:    win.top    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = !q_full;

  lwc_front u_front (
    .tdata (s_tdata),
    .win   (win),
    .job   (front_job)
  );

  lwc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && s_tready),
    .push_job  (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_job   (q_job)
  );

  lwc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .win      (win),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef SYNTHESIS
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("hidden segment with nonzero coordinates");

  a_visible_x_inside: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      $signed(m_tdata[lwc_pkg::CW-1:0]) >= win.left &&
      $signed(m_tdata[lwc_pkg::CW-1:0]) <= win.right)
    else $error("visible start point outside window in x");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule

// File: design/lwc_front.sv
// ----------------------------------------------------------------------------
// lwc_front
// Unpacks an incoming segment and classifies its end points against the window.
// ----------------------------------------------------------------------------
module lwc_front (
  input  logic [4*lwc_pkg::CW-1:0] tdata,
  input  lwc_pkg::win_t            win,
  output lwc_pkg::job_t            job
);

  logic signed [lwc_pkg::CW-1:0] sx, sy, ex, ey;

  assign sx = tdata[lwc_pkg::CW-1:0];
  assign sy = tdata[2*lwc_pkg::CW-1:lwc_pkg::CW];
  assign ex = tdata[3*lwc_pkg::CW-1:2*lwc_pkg::CW];
  assign ey = tdata[4*lwc_pkg::CW-1:3*lwc_pkg::CW];

  always_comb begin
    job.sx  = sx;
    job.sy  = sy;
    job.ex  = ex;
    job.ey  = ey;
    job.dx  = lwc_pkg::DW'(ex) - lwc_pkg::DW'(sx);
    job.dy  = lwc_pkg::DW'(ey) - lwc_pkg::DW'(sy);
    job.oc0 = lwc_pkg::outcode(sx, sy, win);
    job.oc1 = lwc_pkg::outcode(ex, ey, win);
  end

endmodule

// File: design/lwc_queue.sv
// ----------------------------------------------------------------------------
// lwc_queue
// Two-entry queue of classified segments between the front and back parts.
// ----------------------------------------------------------------------------
module lwc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lwc_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output lwc_pkg::job_t pop_job
);

  lwc_pkg::job_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: design/lwc_back.sv
// ----------------------------------------------------------------------------
// lwc_back
// Clipping sequencer: moves outside end points onto window edges using one
// multiply and a bit-serial restoring divide per move, then emits the result.
// ----------------------------------------------------------------------------
module lwc_back (
  input  logic                     clk,
  input  logic                     rst,
  input  lwc_pkg::win_t            win,
  input  logic                     q_valid,
  input  lwc_pkg::job_t            q_job,
  output logic                     q_pop,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [4*lwc_pkg::CW-1:0] m_tdata,
  output logic                     m_tuser
);

  localparam int CW = lwc_pkg::CW;
  localparam int DW = lwc_pkg::DW;
  localparam int PW = lwc_pkg::PW;

  lwc_pkg::back_state_t state, state_next;

  logic signed [CW-1:0] ex, ey;
  logic signed [DW-1:0] dx, dy;
  logic signed [CW-1:0] px [2];
  logic signed [CW-1:0] py [2];
  logic [3:0]           oc [2];
  logic [lwc_pkg::PASS_W-1:0] pass;

  logic                 sel_w;
  logic                 is_x;
  logic signed [CW-1:0] edge_val;
  logic                 neg;
  logic [DW-1:0]        ma, mb, md;
  logic [PW-1:0]        dq;
  logic [DW-1:0]        rem;
  logic [lwc_pkg::BIT_W-1:0] bitcnt;

  // Decision logic for the current pass.
  logic                 both_in, reject, degen, finish;
  logic                 w_c;
  logic [3:0]           c;
  logic                 xedge;
  logic signed [CW-1:0] edge_c;
  logic signed [DW-1:0] a_c, b_c, d_c;
  logic                 out_free;
  logic                 load_out;
  logic [DW:0]          r2;
  logic signed [PW+2:0] sq, base, val;
  logic signed [CW-1:0] new_coord;
  logic signed [CW-1:0] nx, ny;

  always_comb begin
    both_in = ((oc[0] | oc[1]) == 4'b0000);
    reject  = ((oc[0] & oc[1]) != 4'b0000) ||
              (pass == lwc_pkg::PASS_W'(lwc_pkg::CLIP_PASSES));
    w_c     = (oc[0] == 4'b0000);
    c       = w_c ? oc[1] : oc[0];
    xedge   = ((c & (lwc_pkg::OC_LEFT | lwc_pkg::OC_RIGHT)) != 4'b0000);
    degen   = xedge ? (dx == '0) : (dy == '0);
    finish  = both_in || reject || degen;
    if (xedge) begin
      edge_c = ((c & lwc_pkg::OC_LEFT) != 4'b0000) ? win.left : win.right;
      a_c    = dy;
      b_c    = DW'(ex) - DW'(edge_c);
      d_c    = dx;
    end else begin
      edge_c = ((c & lwc_pkg::OC_BOTTOM) != 4'b0000) ? win.bottom : win.top;
      a_c    = dx;
      b_c    = DW'(ey) - DW'(edge_c);
      d_c    = dy;
    end
  end

  assign out_free = !m_tvalid || m_tready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lwc_pkg::ST_IDLE:   if (q_valid) state_next = lwc_pkg::ST_DECIDE;
      lwc_pkg::ST_DECIDE: begin
        if (finish) begin
          if (out_free) state_next = lwc_pkg::ST_IDLE;
        end else begin
          state_next = lwc_pkg::ST_MUL;
        end
      end
      lwc_pkg::ST_MUL:    state_next = lwc_pkg::ST_DIV;
      lwc_pkg::ST_DIV: begin
        if (bitcnt == lwc_pkg::BIT_W'(PW - 1)) state_next = lwc_pkg::ST_UPDATE;
      end
      lwc_pkg::ST_UPDATE: state_next = lwc_pkg::ST_DECIDE;
      default:            state_next = lwc_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    unique case (state)
      lwc_pkg::ST_IDLE:   q_pop    = q_valid;
      lwc_pkg::ST_DECIDE: load_out = finish && out_free;
      default: ;
    endcase
  end

  assign r2 = {rem, dq[PW-1]};

  // Signed quotient, applied to the original end point and clamped.
  always_comb begin
    sq        = neg ? -(PW+3)'(dq) : (PW+3)'(dq);
    base      = is_x ? (PW+3)'(ey) : (PW+3)'(ex);
    val       = base - sq;
    new_coord = lwc_pkg::clamp(val);
    nx        = is_x ? edge_val : new_coord;
    ny        = is_x ? new_coord : edge_val;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      lwc_pkg::ST_IDLE: begin
        ex    <= q_job.ex;
        ey    <= q_job.ey;
        dx    <= q_job.dx;
        dy    <= q_job.dy;
        px[0] <= q_job.sx;
        py[0] <= q_job.sy;
        px[1] <= q_job.ex;
        py[1] <= q_job.ey;
        oc[0] <= q_job.oc0;
        oc[1] <= q_job.oc1;
        pass  <= '0;
      end
      lwc_pkg::ST_DECIDE: begin
        sel_w    <= w_c;
        is_x     <= xedge;
        edge_val <= edge_c;
        neg      <= a_c[DW-1] ^ b_c[DW-1] ^ d_c[DW-1];
        ma       <= lwc_pkg::magnitude(a_c);
        mb       <= lwc_pkg::magnitude(b_c);
        md       <= lwc_pkg::magnitude(d_c);
      end
      lwc_pkg::ST_MUL: begin
        dq     <= PW'(ma) * PW'(mb);
        rem    <= '0;
        bitcnt <= '0;
      end
      lwc_pkg::ST_DIV: begin
        if (r2 >= {1'b0, md}) begin
          rem <= DW'(r2 - {1'b0, md});
          dq  <= {dq[PW-2:0], 1'b1};
        end else begin
          rem <= r2[DW-1:0];
          dq  <= {dq[PW-2:0], 1'b0};
        end
        bitcnt <= bitcnt + lwc_pkg::BIT_W'(1);
      end
      lwc_pkg::ST_UPDATE: begin
        px[sel_w] <= nx;
        py[sel_w] <= ny;
        oc[sel_w] <= lwc_pkg::outcode(nx, ny, win);
        pass      <= pass + lwc_pkg::PASS_W'(1);
      end
      default: ;
    endcase
  end

  // Output register; a hidden segment carries zero coordinates.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= both_in;
      m_tdata <= both_in ? {py[1], px[1], py[0], px[0]} : '0;
    end
  end

endmodule

// File: sim/line_window_clipper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_window_clipper_test
// Streams line segments through the clipper under several window settings,
// with random stalls on both sides, and checks every clipped result beat
// against a Cohen-Sutherland predictor kept inside this bench.
// ----------------------------------------------------------------------------
module line_window_clipper_test;

  localparam int  CW           = lwc_pkg::CW;
  localparam int  LIMIT_CYCLES = 1_500_000;
  localparam int  DRAIN_CYCLES = 2 + 37 * lwc_pkg::CLIP_PASSES + 20;

  typedef struct {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
  } segment_t;

  typedef struct {
    logic                 vis;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
  } clipped_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = lwc_pkg::REG_LEFT;
  logic [CW-1:0]       cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [4*CW-1:0]     s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [4*CW-1:0]     m_tdata;
  logic                m_tuser;

  segment_t            pending_segments[$];
  clipped_t            expected_clips[$];
  longint              win_left = 0, win_bottom = 0, win_right = 639, win_top = 479;
  logic                in_took = 1'b0;
  bit                  calm = 1'b0;
  int                  hold_off = 0;
  int                  cycle_count = 0;
  int                  error_count = 0;
  int                  segments_sent = 0;
  int                  visible_seen = 0;
  int                  hidden_seen = 0;

  line_window_clipper u_dut (.*);

  always #2 clk = ~clk;

  function automatic logic [3:0] region_code(longint x, longint y);
    logic [3:0] c;
    c = 4'b0000;
    if (y > win_top)    c |= lwc_pkg::OC_TOP;
    if (y < win_bottom) c |= lwc_pkg::OC_BOTTOM;
    if (x > win_right)  c |= lwc_pkg::OC_RIGHT;
    if (x < win_left)   c |= lwc_pkg::OC_LEFT;
    return c;
  endfunction

  function automatic longint saturate(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Intersections are always taken from the original end point, with
  // truncating division, so the moved points match the hardware exactly.
  function automatic clipped_t clip_segment(segment_t s);
    longint     px[2];
    longint     py[2];
    longint     dx, dy, nx, ny;
    logic [3:0] oc[2];
    logic [3:0] c;
    int         w;
    clipped_t   r;
    px[0] = s.sx; py[0] = s.sy; px[1] = s.ex; py[1] = s.ey;
    dx = px[1] - px[0];
    dy = py[1] - py[0];
    oc[0] = region_code(px[0], py[0]);
    oc[1] = region_code(px[1], py[1]);
    r.vis = 1'b0;
    for (int pass = 0; pass <= lwc_pkg::CLIP_PASSES; pass++) begin
      if ((oc[0] | oc[1]) == 4'b0000) begin
        r.vis = 1'b1;
        break;
      end
      if ((oc[0] & oc[1]) != 4'b0000 || pass == lwc_pkg::CLIP_PASSES) break;
      w = (oc[0] != 4'b0000) ? 0 : 1;
      c = oc[w];
      if ((c & (lwc_pkg::OC_LEFT | lwc_pkg::OC_RIGHT)) != 4'b0000) begin
        if (dx == 0) break;
        nx = ((c & lwc_pkg::OC_LEFT) != 4'b0000) ? win_left : win_right;
        ny = saturate(longint'(s.ey) - (dy * (longint'(s.ex) - nx)) / dx);
      end else begin
        if (dy == 0) break;
        ny = ((c & lwc_pkg::OC_BOTTOM) != 4'b0000) ? win_bottom : win_top;
        nx = saturate(longint'(s.ex) - (dx * (longint'(s.ey) - ny)) / dy);
      end
      px[w] = nx;
      py[w] = ny;
      oc[w] = region_code(nx, ny);
    end
    r.sx = r.vis ? CW'(px[0]) : '0;
    r.sy = r.vis ? CW'(py[0]) : '0;
    r.ex = r.vis ? CW'(px[1]) : '0;
    r.ey = r.vis ? CW'(py[1]) : '0;
    return r;
  endfunction

  function automatic segment_t make_seg(longint a, longint b, longint c, longint d);
    segment_t s;
    s.sx = CW'(a); s.sy = CW'(b); s.ex = CW'(c); s.ey = CW'(d);
    return s;
  endfunction

  function automatic longint near_x();
    longint base;
    base = $urandom_range(1) ? win_left : win_right;
    return saturate(base + longint'($urandom_range(600)) - 300);
  endfunction

  function automatic longint near_y();
    longint base;
    base = $urandom_range(1) ? win_bottom : win_top;
    return saturate(base + longint'($urandom_range(600)) - 300);
  endfunction

  task automatic add_segment(segment_t s);
    pending_segments = {pending_segments, s};
  endtask

  // Mostly segments around the window edges, with some over the full range.
  task automatic queue_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 70)
        add_segment(make_seg(near_x(), near_y(), near_x(), near_y()));
      else
        add_segment(make_seg(longint'($signed(16'($urandom))),
                             longint'($signed(16'($urandom))),
                             longint'($signed(16'($urandom))),
                             longint'($signed(16'($urandom)))));
    end
  endtask

  task automatic write_window(longint l, longint b, longint r, longint t);
    logic [CW-1:0] vals[4];
    vals[0] = CW'(l); vals[1] = CW'(b); vals[2] = CW'(r); vals[3] = CW'(t);
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (pending_segments.size() == 0 && !s_tvalid);
    wait (expected_clips.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sender: a beat stays up until it is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_took) begin
      if (pending_segments.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
        segment_t s;
        s = pending_segments.pop_front();
        s_tdata  <= {s.ey, s.ex, s.sy, s.sx};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver, with a long hold-off when requested.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off = hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || $urandom_range(99) >= 13;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    in_took <= !rst && s_tvalid && s_tready;
    if (!rst && cfg_we) begin
      case (cfg_index)
        lwc_pkg::REG_LEFT:   win_left   = longint'($signed(cfg_data));
        lwc_pkg::REG_BOTTOM: win_bottom = longint'($signed(cfg_data));
        lwc_pkg::REG_RIGHT:  win_right  = longint'($signed(cfg_data));
        lwc_pkg::REG_TOP:    win_top    = longint'($signed(cfg_data));
        default: ;
      endcase
    end
    if (!rst && s_tvalid && s_tready) begin
      expected_clips = {expected_clips, clip_segment(make_seg(
        longint'($signed(s_tdata[CW-1:0])),    longint'($signed(s_tdata[2*CW-1:CW])),
        longint'($signed(s_tdata[3*CW-1:2*CW])), longint'($signed(s_tdata[4*CW-1:3*CW]))))};
      segments_sent++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_clips.size() == 0) begin
        $display("%0t unexpected result: expected none, actual vis=%0b data=%h",
                 $time, m_tuser, m_tdata);
        error_count++;
      end else begin
        clipped_t e;
        e = expected_clips.pop_front();
        if (m_tuser !== e.vis || m_tdata !== {e.ey, e.ex, e.sy, e.sx}) begin
          $display({"%0t mismatch: expected vis=%0b (%0d,%0d)-(%0d,%0d), ",
                    "actual vis=%0b (%0d,%0d)-(%0d,%0d)"},
                   $time, e.vis, e.sx, e.sy, e.ex, e.ey, m_tuser,
                   $signed(m_tdata[CW-1:0]), $signed(m_tdata[2*CW-1:CW]),
                   $signed(m_tdata[3*CW-1:2*CW]), $signed(m_tdata[4*CW-1:3*CW]));
          error_count++;
        end
        if (e.vis) visible_seen++;
        else hidden_seen++;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset window 0..639 x 0..479: the classic cases.
    add_segment(make_seg(10, 10, 600, 400));        // fully inside
    add_segment(make_seg(-50, -50, -10, 300));      // left of window
    add_segment(make_seg(700, 10, 900, 400));       // right of window
    add_segment(make_seg(10, -5, 600, -100));       // below window
    add_segment(make_seg(10, 500, 600, 900));       // above window
    add_segment(make_seg(-100, 200, 300, 250));     // crosses left edge
    add_segment(make_seg(300, 200, 1000, 100));     // crosses right edge
    add_segment(make_seg(100, -300, 200, 100));     // crosses bottom edge
    add_segment(make_seg(100, 100, 150, 800));      // crosses top edge
    add_segment(make_seg(-200, -200, 900, 700));    // runs between two corner regions
    add_segment(make_seg(-10, 470, 20, 520));       // misses near a corner
    add_segment(make_seg(320, -1000, 320, 1000));   // vertical
    add_segment(make_seg(-1000, 240, 1000, 240));   // horizontal
    add_segment(make_seg(50, 50, 50, 50));          // single point inside
    add_segment(make_seg(-32768, -32768, 32767, 32767));
    add_segment(make_seg(32767, -32768, -32768, 32767));
    add_segment(make_seg(-32768, 100, 32767, 101));
    add_segment(make_seg(0, 0, 639, 479));          // on the borders
    add_segment(make_seg(-1, 0, 640, 479));
    queue_random(80);
    wait_idle();

    // Extreme window; the receiver stalls long enough to back up the input.
    write_window(-32768, -32768, 32767, 32767);
    calm = 1'b1;
    queue_random(60);
    @(posedge clk);
    hold_off = 1500;
    wait_idle();
    calm = 1'b0;

    // Small window; saturating intersections far outside show up here.
    write_window(-20, -10, 30, 15);
    add_segment(make_seg(-32768, 32767, 32767, -32768));
    add_segment(make_seg(-32768, 0, 32767, 1));
    queue_random(100);
    wait_idle();

    // Inverted window: left above right and bottom above top.
    write_window(300, 200, -300, -200);
    queue_random(80);
    wait_idle();

    // Narrow off-center window, then back to default-like values.
    write_window(32000, -32768, 32767, -32000);
    queue_random(60);
    wait_idle();
    write_window(0, 0, 639, 479);
    queue_random(100);
    wait_idle();

    $display("clipped %0d segments over six window settings: %0d visible, %0d rejected",
             segments_sent, visible_seen, hidden_seen);
    if (error_count == 0 && expected_clips.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results still expected", error_count,
               expected_clips.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: line_window_clipper.f
design/lwc_pkg.sv
design/lwc_front.sv
design/lwc_queue.sv
design/lwc_back.sv
design/line_window_clipper.sv
sim/line_window_clipper_test.sv
